// File: hw/rtl/ecb_pkg.sv
package ecb_pkg;

  localparam int unsigned CHANNEL_BITS    = 8;
  localparam int unsigned NUM_CHANNELS    = 4;
  localparam int unsigned PHASE_FRAC_BITS = 16;
  localparam int unsigned PHASE_BITS      = PHASE_FRAC_BITS + 1;
  localparam int unsigned COS_TABLE_DEPTH = 256;
  localparam int unsigned MODE_BITS       = 3;
  localparam int unsigned SHAPE_LATENCY   = 4;

  localparam logic [MODE_BITS-1:0] CURVE_LINEAR   = 3'd0;
  localparam logic [MODE_BITS-1:0] CURVE_SMOOTH   = 3'd1;
  localparam logic [MODE_BITS-1:0] CURVE_SMOOTHER = 3'd2;
  localparam logic [MODE_BITS-1:0] CURVE_COSINE   = 3'd3;
  localparam logic [MODE_BITS-1:0] CURVE_CUBIC    = 3'd4;

  localparam logic [PHASE_BITS-1:0] PHASE_ONE = {1'b1, {PHASE_FRAC_BITS{1'b0}}};

  typedef logic [PHASE_BITS-1:0] phase_t;

  typedef struct packed {
    logic                 valid;
    logic [MODE_BITS-1:0] mode;
    phase_t               phase;
  } shape_req_t;

  typedef struct packed {
    logic   valid;
    phase_t weight;
  } shape_rsp_t;

endpackage

// File: hw/rtl/eased_color_blend_unit.sv
// Eased color blend unit.
// Blends two RGBA colors, 8 bits per channel, with a weight taken from the blend
// phase (unsigned Q1.16, clamped to one) and shaped by the selected curve:
// linear, smoothstep, smootherstep, cosine ease or cubic ease.
// Input: a beat is taken at each rising clock edge with start high and busy low.
// busy is always low, so a new beat may enter in every cycle.
// Configuration: curve_mode is written from cfg_data_i when cfg_valid_i is high;
// cfg_ready_o is always high. Write it only while no beat is in flight.
// Output: done_o is high for one cycle with the blended color on the mixed ports,
// once the beat has passed the register stages below. Throughput is one beat per cycle.
// The latency comes from seven register stages: input capture, four curve stages
// (squares, cubes and table read, the last product, curve select), the channel
// multipliers and the final round and clamp.
// Results are presented once and cannot be held off; the unit never stalls.
// Reset clears all valid bits, drops beats in flight and selects the linear curve.
module eased_color_blend_unit #(
  parameter int unsigned COS_TABLE_DEPTH = ecb_pkg::COS_TABLE_DEPTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  ecb_pkg::phase_t                       blend_phase_i,
  input  logic [ecb_pkg::CHANNEL_BITS-1:0]      first_red_i,
  input  logic [ecb_pkg::CHANNEL_BITS-1:0]      first_green_i,
  input  logic [ecb_pkg::CHANNEL_BITS-1:0]      first_blue_i,
  input  logic [ecb_pkg::CHANNEL_BITS-1:0]      first_alpha_i,
  input  logic [ecb_pkg::CHANNEL_BITS-1:0]      second_red_i,
  input  logic [ecb_pkg::CHANNEL_BITS-1:0]      second_green_i,
  input  logic [ecb_pkg::CHANNEL_BITS-1:0]      second_blue_i,
  input  logic [ecb_pkg::CHANNEL_BITS-1:0]      second_alpha_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ecb_pkg::MODE_BITS-1:0]         cfg_data_i,
  output logic                                  done_o,
  output logic [ecb_pkg::CHANNEL_BITS-1:0]      mixed_red_o,
  output logic [ecb_pkg::CHANNEL_BITS-1:0]      mixed_green_o,
  output logic [ecb_pkg::CHANNEL_BITS-1:0]      mixed_blue_o,
  output logic [ecb_pkg::CHANNEL_BITS-1:0]      mixed_alpha_o
);

  localparam int unsigned CB         = ecb_pkg::CHANNEL_BITS;
  localparam int unsigned NC         = ecb_pkg::NUM_CHANNELS;
  localparam int unsigned F          = ecb_pkg::PHASE_FRAC_BITS;
  localparam int unsigned PW         = ecb_pkg::PHASE_BITS;
  localparam int unsigned PRW        = PW + CB;
  localparam int unsigned SUMW       = PRW + 1;
  localparam int unsigned SL         = ecb_pkg::SHAPE_LATENCY;
  localparam int unsigned PIPE_DEPTH = SL + 3;
  localparam logic [PW-1:0] ONE      = ecb_pkg::PHASE_ONE;

  typedef logic [NC-1:0][CB-1:0] chan_vec_t;

  logic [ecb_pkg::MODE_BITS-1:0] curve_mode_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_mode_q <= ecb_pkg::CURVE_LINEAR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      curve_mode_q <= cfg_data_i;
    end
  end

  // Stage 1: capture the beat and clamp the phase.
  logic                          s1_valid_q;
  logic [ecb_pkg::MODE_BITS-1:0] s1_mode_q;
  ecb_pkg::phase_t               s1_phase_q;
  chan_vec_t                     s1_first_q, s1_second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mode_q   <= curve_mode_q;
    s1_phase_q  <= (blend_phase_i > ONE) ? ONE : blend_phase_i;
    s1_first_q  <= {first_alpha_i, first_blue_i, first_green_i, first_red_i};
    s1_second_q <= {second_alpha_i, second_blue_i, second_green_i, second_red_i};
  end

  ecb_pkg::shape_req_t shape_req;
  ecb_pkg::shape_rsp_t shape_rsp;

  always_comb begin
    shape_req.valid = s1_valid_q;
    shape_req.mode  = s1_mode_q;
    shape_req.phase = s1_phase_q;
  end

  ecb_shape #(
    .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
  ) u_shape (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (shape_req),
    .rsp_o (shape_rsp)
  );

  // The colors wait alongside the curve pipeline.
  chan_vec_t first_dly_q  [SL];
  chan_vec_t second_dly_q [SL];

  always_ff @(posedge clk_i) begin
    first_dly_q[0]  <= s1_first_q;
    second_dly_q[0] <= s1_second_q;
    for (int i = 1; i < SL; i++) begin
      first_dly_q[i]  <= first_dly_q[i-1];
      second_dly_q[i] <= second_dly_q[i-1];
    end
  end

  // Stage 6: channel products.
  logic           s6_valid_q;
  logic [PRW-1:0] prod_a_q [NC];
  logic [PRW-1:0] prod_b_q [NC];
  logic [PW-1:0]  inv_w;

  assign inv_w = ONE - shape_rsp.weight;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else begin
      s6_valid_q <= shape_rsp.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NC; c++) begin
      prod_a_q[c] <= PRW'(first_dly_q[SL-1][c]) * PRW'(inv_w);
      prod_b_q[c] <= PRW'(second_dly_q[SL-1][c]) * PRW'(shape_rsp.weight);
    end
  end

  // Stage 7: sum, round to nearest and clamp.
  logic [SUMW-1:0] sum   [NC];
  logic [SUMW-1:0] rsum  [NC];
  chan_vec_t       mix_d;
  chan_vec_t       mix_q;
  logic            done_q;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      sum[c]  = SUMW'(prod_a_q[c]) + SUMW'(prod_b_q[c]);
      rsum[c] = sum[c] + (SUMW'(1) << (F - 1));
      if (rsum[c][SUMW-1:F+CB] != '0) begin
        mix_d[c] = '1;
      end else begin
        mix_d[c] = rsum[c][F+CB-1:F];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mix_q <= mix_d;
  end

  assign done_o        = done_q;
  assign mixed_red_o   = mix_q[0];
  assign mixed_green_o = mix_q[1];
  assign mixed_blue_o  = mix_q[2];
  assign mixed_alpha_o = mix_q[3];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PIPE_DEPTH done_o)
    else $error("Accepted beat gave no result at the expected latency.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |->
      (mixed_red_o >= $past(first_red_i, PIPE_DEPTH) ||
       mixed_red_o >= $past(second_red_i, PIPE_DEPTH)) &&
      (mixed_red_o <= $past(first_red_i, PIPE_DEPTH) ||
       mixed_red_o <= $past(second_red_i, PIPE_DEPTH)))
    else $error("Blended red lies outside the two input colors.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && blend_phase_i == '0) |-> ##PIPE_DEPTH
      (mixed_red_o == $past(first_red_i, PIPE_DEPTH) &&
       mixed_alpha_o == $past(first_alpha_i, PIPE_DEPTH)))
    else $error("Zero phase did not return the first color.");

endmodule

// File: hw/rtl/ecb_shape.sv
module ecb_shape #(
  parameter int unsigned COS_TABLE_DEPTH = ecb_pkg::COS_TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ecb_pkg::shape_req_t req_i,
  output ecb_pkg::shape_rsp_t rsp_o
);

  localparam int unsigned F   = ecb_pkg::PHASE_FRAC_BITS;
  localparam int unsigned PW  = ecb_pkg::PHASE_BITS;
  localparam int unsigned PW2 = 2 * PW;
  localparam int unsigned QW  = F + 4;
  localparam int unsigned MW  = ecb_pkg::MODE_BITS;
  localparam int unsigned IW  = $clog2(COS_TABLE_DEPTH + 1);
  localparam logic [PW-1:0]  ONE     = ecb_pkg::PHASE_ONE;
  localparam logic [63:0]    PI_Q30  = 64'd3373259426;
  localparam logic [PW2-1:0] HALF_F  = PW2'(1) << (F - 1);

  function automatic logic [63:0] half_cos_low(input int unsigned k);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] sum;
    a    = (PI_Q30 * 64'(k) * 64'd2 / 64'(COS_TABLE_DEPTH) + 64'd1) >> 1;
    a2   = (a * a + (64'd1 << 29)) >> 30;
    term = a2 >> 1;
    sum  = term;
    term = ((term * a2) >> 30) / 64'd12;
    sum  = sum - term;
    term = ((term * a2) >> 30) / 64'd30;
    sum  = sum + term;
    term = ((term * a2) >> 30) / 64'd56;
    sum  = sum - term;
    term = ((term * a2) >> 30) / 64'd90;
    sum  = sum + term;
    term = ((term * a2) >> 30) / 64'd132;
    sum  = sum - term;
    term = ((term * a2) >> 30) / 64'd182;
    sum  = sum + term;
    return (sum + (64'd1 << (30 - F))) >> (31 - F);
  endfunction

  function automatic logic [PW-1:0] cos_entry(input int unsigned k);
    logic [63:0] v;
    if (k >= COS_TABLE_DEPTH) begin
      return ONE;
    end
    if (2 * k <= COS_TABLE_DEPTH) begin
      v = half_cos_low(k);
      return PW'(v);
    end
    v = half_cos_low(COS_TABLE_DEPTH - k);
    return ONE - PW'(v);
  endfunction

  logic [PW-1:0] cos_tbl [COS_TABLE_DEPTH+1];

  for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_cos
    localparam logic [PW-1:0] ENTRY = cos_entry(k);
    assign cos_tbl[k] = ENTRY;
  end

  // Stage 2: squares, smootherstep inner polynomial, cosine table index.
  logic            s2_valid_q;
  logic [MW-1:0]   s2_mode_q;
  logic [PW-1:0]   s2_t_q, s2_t2_q, s2_g_q, s2_g2_q;
  logic [PW:0]     s2_sss_q;
  logic [QW-1:0]   s2_q_q;
  logic [IW-1:0]   s2_idx_q, s2_idx1_q;
  logic [F-1:0]    s2_frac_q;
  logic            s2_lo_q;

  logic [PW-1:0]     t;
  logic [PW2-1:0]    tt, gg;
  logic [QW-1:0]     c15m6;
  logic [PW+QW-1:0]  tq;
  logic [PW-1:0]     omt, g_d;
  logic [PW+IW-1:0]  p;
  logic [IW-1:0]     idx_d;

  always_comb begin
    t     = req_i.phase;
    tt    = PW2'(t) * PW2'(t);
    c15m6 = (QW'(15) << F) - QW'(t) * QW'(6);
    tq    = (PW+QW)'(t) * (PW+QW)'(c15m6);
    omt   = ONE - t;
    g_d   = {omt[PW-2:0], 1'b0};
    gg    = PW2'(g_d) * PW2'(g_d);
    p     = (PW+IW)'(t) * (PW+IW)'(COS_TABLE_DEPTH);
    idx_d = IW'(p >> F);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_mode_q <= req_i.mode;
    s2_t_q    <= t;
    s2_t2_q   <= PW'((tt + HALF_F) >> F);
    s2_q_q    <= QW'((tq + (PW+QW)'(HALF_F)) >> F);
    s2_g_q    <= g_d;
    s2_g2_q   <= PW'((gg + HALF_F) >> F);
    s2_sss_q  <= ((PW+1)'(3) << F) - ((PW+1)'(t) << 1);
    s2_idx_q  <= idx_d;
    s2_idx1_q <= (idx_d == IW'(COS_TABLE_DEPTH)) ? idx_d : idx_d + IW'(1);
    s2_frac_q <= p[F-1:0];
    s2_lo_q   <= t < (ONE >> 1);
  end

  // Stage 3: cubes, smoothstep and cubic weights, table reads.
  logic            s3_valid_q;
  logic [MW-1:0]   s3_mode_q;
  logic [PW-1:0]   s3_t_q, s3_t3_q, s3_wss_q, s3_wcub_q, s3_e0_q, s3_e1_q;
  logic [QW-1:0]   s3_r_q;
  logic [F-1:0]    s3_frac_q;

  logic [PW2-1:0]   pt, pg;
  logic [PW2:0]     ps;
  logic [PW-1:0]    cub_lo, cub_hi;

  always_comb begin
    pt     = PW2'(s2_t2_q) * PW2'(s2_t_q);
    ps     = (PW2+1)'(s2_t2_q) * (PW2+1)'(s2_sss_q);
    pg     = PW2'(s2_g2_q) * PW2'(s2_g_q);
    cub_lo = PW'((pt + (PW2'(1) << (F - 3))) >> (F - 2));
    cub_hi = ONE - PW'((pg + (PW2'(1) << F)) >> (F + 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_mode_q <= s2_mode_q;
    s3_t_q    <= s2_t_q;
    s3_t3_q   <= PW'((pt + HALF_F) >> F);
    s3_wss_q  <= PW'((ps + (PW2+1)'(HALF_F)) >> F);
    s3_wcub_q <= s2_lo_q ? cub_lo : cub_hi;
    s3_r_q    <= (QW'(10) << F) - s2_q_q;
    s3_e0_q   <= cos_tbl[s2_idx_q];
    s3_e1_q   <= cos_tbl[s2_idx1_q];
    s3_frac_q <= s2_frac_q;
  end

  // Stage 4: smootherstep weight and cosine interpolation step.
  logic            s4_valid_q;
  logic [MW-1:0]   s4_mode_q;
  logic [PW-1:0]   s4_t_q, s4_wss_q, s4_wcub_q, s4_e0_q, s4_dm_q;
  logic [QW-1:0]   s4_wsms_q;
  logic            s4_up_q;

  logic [PW+QW-1:0] pm;
  logic             up;
  logic [PW-1:0]    diff;
  logic [PW+F-1:0]  pd;

  always_comb begin
    pm   = (PW+QW)'(s3_t3_q) * (PW+QW)'(s3_r_q);
    up   = s3_e1_q >= s3_e0_q;
    diff = up ? (s3_e1_q - s3_e0_q) : (s3_e0_q - s3_e1_q);
    pd   = (PW+F)'(diff) * (PW+F)'(s3_frac_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_mode_q <= s3_mode_q;
    s4_t_q    <= s3_t_q;
    s4_wss_q  <= s3_wss_q;
    s4_wcub_q <= s3_wcub_q;
    s4_wsms_q <= QW'((pm + (PW+QW)'(HALF_F)) >> F);
    s4_e0_q   <= s3_e0_q;
    s4_up_q   <= up;
    s4_dm_q   <= PW'((pd + (PW+F)'(HALF_F)) >> F);
  end

  // Stage 5: curve select and saturation.
  logic [QW-1:0] wsel;
  logic [PW-1:0] weight_d;
  logic          rsp_valid_q;
  logic [PW-1:0] rsp_weight_q;

  always_comb begin
    case (s4_mode_q)
      ecb_pkg::CURVE_SMOOTH: begin
        wsel = QW'(s4_wss_q);
      end
      ecb_pkg::CURVE_SMOOTHER: begin
        wsel = s4_wsms_q;
      end
      ecb_pkg::CURVE_COSINE: begin
        wsel = s4_up_q ? (QW'(s4_e0_q) + QW'(s4_dm_q)) : (QW'(s4_e0_q) - QW'(s4_dm_q));
      end
      ecb_pkg::CURVE_CUBIC: begin
        wsel = QW'(s4_wcub_q);
      end
      default: begin
        wsel = QW'(s4_t_q);
      end
    endcase
    weight_d = (wsel > QW'(ONE)) ? ONE : PW'(wsel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_weight_q <= weight_d;
  end

  assign rsp_o = '{valid: rsp_valid_q, weight: rsp_weight_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid |-> ##(ecb_pkg::SHAPE_LATENCY) rsp_o.valid)
    else $error("Curve pipeline dropped a beat.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.weight <= ONE)
    else $error("Blend weight exceeds one.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.phase == ONE) |-> ##(ecb_pkg::SHAPE_LATENCY) rsp_o.weight == ONE)
    else $error("Full phase did not give full weight.");

endmodule

// File: sim/tb_eased_color_blend_unit.sv
`timescale 1ns / 100ps

module tb_eased_color_blend_unit;

  import ecb_pkg::*;

  typedef bit [63:0] u64_t;
  typedef logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] rgba_t;

  typedef struct packed {
    phase_t phase;
    rgba_t  first_rgba;
    rgba_t  second_rgba;
  } blend_item_t;

  localparam logic [MODE_BITS-1:0] CURVE_SPARE_5 = 3'd5;
  localparam logic [MODE_BITS-1:0] CURVE_SPARE_6 = 3'd6;
  localparam logic [MODE_BITS-1:0] CURVE_SPARE_7 = 3'd7;
  localparam logic [MODE_BITS-1:0] CURVE_PLAN [8] = '{CURVE_LINEAR, CURVE_SMOOTH,
    CURVE_SMOOTHER, CURVE_COSINE, CURVE_CUBIC, CURVE_SPARE_5, CURVE_SPARE_6, CURVE_SPARE_7};

  localparam u64_t UNITY       = 64'd1 << PHASE_FRAC_BITS;
  localparam u64_t CHANNEL_MAX = (64'd1 << CHANNEL_BITS) - 1;
  localparam u64_t PI_Q30      = 64'd3373259426;
  localparam int   GAP_PLAN [3] = '{0, 54, 15};
  localparam int   ITEMS_PER_PHASE = 54;
  localparam int   SETTLE_CYCLES = 12;
  localparam int   SHOW_LIMIT = 10;
  localparam phase_t PHASE_CORNERS [12] = '{17'd0, 17'd1, 17'd2, 17'd16384, 17'd32767,
    17'd32768, 17'd32769, 17'd49152, 17'd65535, 17'd65536, 17'd65537, 17'd131071};

  logic        clk_i;
  logic        rst_ni;
  logic        start = 1'b0;
  logic        busy;
  phase_t      blend_phase_i = '0;
  rgba_t       first_rgba_drv = '0;
  rgba_t       second_rgba_drv = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [MODE_BITS-1:0] cfg_data_i = '0;
  logic        done_o;
  logic [CHANNEL_BITS-1:0] mixed_red_o, mixed_green_o, mixed_blue_o, mixed_alpha_o;

  blend_item_t pending_items[$];
  rgba_t       expected_colors[$];
  blend_item_t drive_item;
  logic [MODE_BITS-1:0] curve_sel = CURVE_LINEAR;
  int          gap_pct = 0;
  int          error_count = 0;
  int          shown_count = 0;

  eased_color_blend_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .blend_phase_i  (blend_phase_i),
    .first_red_i    (first_rgba_drv[0]),
    .first_green_i  (first_rgba_drv[1]),
    .first_blue_i   (first_rgba_drv[2]),
    .first_alpha_i  (first_rgba_drv[3]),
    .second_red_i   (second_rgba_drv[0]),
    .second_green_i (second_rgba_drv[1]),
    .second_blue_i  (second_rgba_drv[2]),
    .second_alpha_i (second_rgba_drv[3]),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .mixed_red_o    (mixed_red_o),
    .mixed_green_o  (mixed_green_o),
    .mixed_blue_o   (mixed_blue_o),
    .mixed_alpha_o  (mixed_alpha_o)
  );

  function automatic void enqueue_item(blend_item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic void enqueue_color(rgba_t color);
    expected_colors = {expected_colors, color};
  endfunction

  function automatic u64_t round_shift(u64_t x, int unsigned s);
    return (x + (64'd1 << (s - 1))) >> s;
  endfunction

  // Half of one minus the cosine, from a truncated Taylor series in Q30.
  function automatic u64_t half_cos_low(u64_t k);
    u64_t ang, ang2, term, acc;
    int unsigned n;
    ang = (PI_Q30 * k * 2 / COS_TABLE_DEPTH + 1) >> 1;
    ang2 = round_shift(ang * ang, 30);
    term = ang2 / 2;
    acc = term;
    for (n = 2; n <= 7; n++) begin
      term = ((term * ang2) >> 30) / u64_t'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        acc = acc + term;
      end else begin
        acc = acc - term;
      end
    end
    return round_shift(acc, 31 - PHASE_FRAC_BITS);
  endfunction

  function automatic u64_t cos_ease_entry(u64_t k);
    if (k >= COS_TABLE_DEPTH) begin
      return UNITY;
    end
    if (2 * k <= COS_TABLE_DEPTH) begin
      return half_cos_low(k);
    end
    return UNITY - half_cos_low(COS_TABLE_DEPTH - k);
  endfunction

  function automatic u64_t eased_weight(logic [MODE_BITS-1:0] mode, u64_t t);
    u64_t w, t2, t3, q, g, g2, p, idx, frac, e0, e1;
    case (mode)
      CURVE_SMOOTH: begin
        t2 = round_shift(t * t, PHASE_FRAC_BITS);
        w = round_shift(t2 * (3 * UNITY - 2 * t), PHASE_FRAC_BITS);
      end
      CURVE_SMOOTHER: begin
        t2 = round_shift(t * t, PHASE_FRAC_BITS);
        t3 = round_shift(t2 * t, PHASE_FRAC_BITS);
        q = round_shift(t * (15 * UNITY - 6 * t), PHASE_FRAC_BITS);
        w = round_shift(t3 * (10 * UNITY - q), PHASE_FRAC_BITS);
      end
      CURVE_COSINE: begin
        p = t * COS_TABLE_DEPTH;
        idx = p >> PHASE_FRAC_BITS;
        frac = p & (UNITY - 1);
        e0 = cos_ease_entry(idx);
        if (idx >= COS_TABLE_DEPTH) begin
          w = e0;
        end else begin
          e1 = cos_ease_entry(idx + 1);
          if (e1 >= e0) begin
            w = e0 + round_shift((e1 - e0) * frac, PHASE_FRAC_BITS);
          end else begin
            w = e0 - round_shift((e0 - e1) * frac, PHASE_FRAC_BITS);
          end
        end
      end
      CURVE_CUBIC: begin
        if (t < UNITY / 2) begin
          t2 = round_shift(t * t, PHASE_FRAC_BITS);
          w = round_shift(4 * t2 * t, PHASE_FRAC_BITS);
        end else begin
          g = 2 * (UNITY - t);
          g2 = round_shift(g * g, PHASE_FRAC_BITS);
          w = UNITY - round_shift(g2 * g, PHASE_FRAC_BITS + 1);
        end
      end
      default: begin
        w = t;
      end
    endcase
    return (w > UNITY) ? UNITY : w;
  endfunction

  function automatic rgba_t blended_color(blend_item_t it, logic [MODE_BITS-1:0] mode);
    u64_t t, w, v;
    rgba_t mix;
    t = u64_t'(it.phase);
    if (t > UNITY) begin
      t = UNITY;
    end
    w = eased_weight(mode, t);
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      v = round_shift(u64_t'(it.first_rgba[c]) * (UNITY - w) + u64_t'(it.second_rgba[c]) * w,
                      PHASE_FRAC_BITS);
      if (v > CHANNEL_MAX) begin
        v = CHANNEL_MAX;
      end
      mix[c] = v[CHANNEL_BITS-1:0];
    end
    return mix;
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] random_channel();
    if ($urandom_range(4) == 0) begin
      return $urandom_range(1) ? '1 : '0;
    end
    return CHANNEL_BITS'($urandom_range(int'(CHANNEL_MAX)));
  endfunction

  function automatic blend_item_t random_item();
    blend_item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      it.phase = PHASE_CORNERS[$urandom_range(11)];
    end else if (pick < 40) begin
      it.phase = PHASE_BITS'($urandom_range(131071, 65537));
    end else begin
      it.phase = PHASE_BITS'($urandom_range(65536));
    end
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      it.first_rgba[c] = random_channel();
      it.second_rgba[c] = random_channel();
    end
    return it;
  endfunction

  task automatic drain_pipeline();
    while (pending_items.size() != 0 || start || expected_colors.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_curve(logic [MODE_BITS-1:0] mode);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    curve_sel = mode;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      blend_phase_i <= '0;
      first_rgba_drv <= '0;
      second_rgba_drv <= '0;
    end else begin
      if (start && !busy) begin
        enqueue_color(blended_color(drive_item, curve_sel));
      end
      if (!start || !busy) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
          drive_item = pending_items.pop_front();
          start <= 1'b1;
          blend_phase_i <= drive_item.phase;
          first_rgba_drv <= drive_item.first_rgba;
          second_rgba_drv <= drive_item.second_rgba;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    rgba_t seen, want;
    string names [4];
    names = '{"red", "green", "blue", "alpha"};
    if (rst_ni && done_o) begin
      seen = {mixed_alpha_o, mixed_blue_o, mixed_green_o, mixed_red_o};
      if (expected_colors.size() == 0) begin
        error_count++;
        if (shown_count < SHOW_LIMIT) begin
          shown_count++;
          $display("%0t: unexpected beat, actual color %h", $time, seen);
        end
      end else begin
        want = expected_colors.pop_front();
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (seen[c] !== want[c]) begin
            error_count++;
            if (shown_count < SHOW_LIMIT) begin
              shown_count++;
              $display("%0t: %s mismatch, expected %0d actual %0d", $time, names[c],
                       want[c], seen[c]);
            end
          end
        end
      end
    end
  end

  initial begin
    blend_item_t it;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The curve is still at its reset value here.
    for (int i = 0; i < 12; i++) begin
      for (int pat = 0; pat < 2; pat++) begin
        it.phase = PHASE_CORNERS[i];
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          it.first_rgba[c] = ((c + pat) % 2 == 0) ? '0 : '1;
          it.second_rgba[c] = ~it.first_rgba[c];
        end
        enqueue_item(it);
      end
    end
    drain_pipeline();

    foreach (GAP_PLAN[g]) begin
      foreach (CURVE_PLAN[m]) begin
        gap_pct = GAP_PLAN[g];
        write_curve(CURVE_PLAN[m]);
        repeat (ITEMS_PER_PHASE) enqueue_item(random_item());
        drain_pipeline();
      end
    end

    error_count += expected_colors.size();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ecb_pkg.sv
hw/rtl/ecb_shape.sv
hw/rtl/eased_color_blend_unit.sv
sim/tb_eased_color_blend_unit.sv
